[hw/rtl/ims_pkg.sv]
// Types, constants and helper functions shared by the IMU status demux and scaling block.
// Depends on nothing; all block files but the queue refer to it by scoped names.
`default_nettype none

package ims_pkg;

  // Message counters that carry special status bytes.
  localparam logic [7:0] FILTER_COUNT = 8'd247;
  localparam logic [7:0] BOARD_FIRST  = 8'd248;
  localparam logic [7:0] BOARD_END    = 8'd252;
  localparam logic [7:0] REV_COUNT    = 8'd0;
  localparam logic [7:0] PROD_COUNT   = 8'd1;

  // Status byte decoding.
  localparam int unsigned SCALE_SEL_BIT   = 6;
  localparam logic [7:0]  RATE_CODE_MASK  = 8'h31;

  // Rate scale codes after masking.
  localparam logic [7:0] RATE_CODE_15 = 8'h11;
  localparam logic [7:0] RATE_CODE_50 = 8'h21;
  localparam logic [7:0] RATE_CODE_5  = 8'h31;

  localparam int unsigned ACCEL_MULT_W = 5;
  localparam int unsigned RATE_MULT_W  = 6;
  localparam int unsigned AXIS_W       = 32;
  localparam int unsigned TEMP_W       = 16;
  localparam int unsigned PROD_W       = AXIS_W + RATE_MULT_W + 1;

  typedef logic [ACCEL_MULT_W-1:0] accel_mult_t;
  typedef logic [RATE_MULT_W-1:0]  rate_mult_t;

  // One classified message, as handed from the front end to the scaler.
  typedef struct packed {
    accel_mult_t              accel_mult;
    rate_mult_t               rate_mult;
    logic signed [AXIS_W-1:0] raw_accel_x;
    logic signed [AXIS_W-1:0] raw_accel_y;
    logic signed [AXIS_W-1:0] raw_accel_z;
    logic signed [AXIS_W-1:0] raw_rate_x;
    logic signed [AXIS_W-1:0] raw_rate_y;
    logic signed [AXIS_W-1:0] raw_rate_z;
    logic signed [TEMP_W-1:0] temperature;
    logic [23:0]              status_word;
    logic [31:0]              board_word;
  } entry_t;

  // Acceleration multiplier picked by status bits 3:1.
  function automatic accel_mult_t accel_mult_of(input logic [2:0] code);
    accel_mult_t m;
    unique case (code)
      3'd0:    m = ACCEL_MULT_W'(10);
      3'd1:    m = ACCEL_MULT_W'(1);
      3'd2:    m = ACCEL_MULT_W'(1);
      3'd3:    m = ACCEL_MULT_W'(5);
      3'd4:    m = ACCEL_MULT_W'(5);
      3'd5:    m = ACCEL_MULT_W'(5);
      3'd6:    m = ACCEL_MULT_W'(10);
      default: m = ACCEL_MULT_W'(20);
    endcase
    return m;
  endfunction

  // Rate multiplier picked by the masked status byte.
  function automatic rate_mult_t rate_mult_of(input logic [7:0] code);
    rate_mult_t m;
    unique case (code)
      RATE_CODE_15: m = RATE_MULT_W'(15);
      RATE_CODE_50: m = RATE_MULT_W'(50);
      RATE_CODE_5:  m = RATE_MULT_W'(5);
      default:      m = RATE_MULT_W'(10);
    endcase
    return m;
  endfunction

  // Signed axis value times a small unsigned multiplier, clamped to 32 bits.
  function automatic logic signed [AXIS_W-1:0] sat_mul(input logic signed [AXIS_W-1:0] raw,
                                                       input rate_mult_t mult);
    logic signed [PROD_W-1:0]  prod;
    logic signed [AXIS_W-1:0]  res;
    prod = PROD_W'(raw) * $signed({1'b0, mult});
    if (!prod[PROD_W-1] && (prod[PROD_W-2:AXIS_W-1] != '0)) begin
      res = {1'b0, {(AXIS_W-1){1'b1}}};
    end else if (prod[PROD_W-1] && (prod[PROD_W-2:AXIS_W-1] != '1)) begin
      res = {1'b1, {(AXIS_W-1){1'b0}}};
    end else begin
      res = prod[AXIS_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/imu_status_demux_and_scaling.sv]
// Top level of the IMU status demux and scaling block: front end, queue and scaler.
// Depends on ims_pkg, ims_front, ims_queue and ims_back.
//
//   channel   direction   handshake               payload
//   in_       input       in_valid / in_ready     counter, status byte, six axes, temperature
//   out_      output      out_valid / out_ready   scale flag, six scaled axes, temperature, words
//
// One message per cycle is sustained while the output does not stall. An accepted message is
// written into the queue, then loaded into the output register, from which its result transfers.
// The throughput is set by the single output register, which is reloaded in the cycle it drains.
// Reset (rst_n low, synchronous) clears the stored status, multipliers, queue and out_valid.
// When the output stalls, the queue holds up to QUEUE_DEPTH messages before in_ready drops.
`default_nettype none

module imu_status_demux_and_scaling #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_msg_counter,
  input  wire logic [7:0]           in_status_byte,
  input  wire logic signed [31:0]   in_raw_accel_x,
  input  wire logic signed [31:0]   in_raw_accel_y,
  input  wire logic signed [31:0]   in_raw_accel_z,
  input  wire logic signed [31:0]   in_raw_rate_x,
  input  wire logic signed [31:0]   in_raw_rate_y,
  input  wire logic signed [31:0]   in_raw_rate_z,
  input  wire logic signed [15:0]   in_raw_temperature,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_scale_known,
  output logic signed [31:0]        out_accel_x_out,
  output logic signed [31:0]        out_accel_y_out,
  output logic signed [31:0]        out_accel_z_out,
  output logic signed [31:0]        out_rate_x_out,
  output logic signed [31:0]        out_rate_y_out,
  output logic signed [31:0]        out_rate_z_out,
  output logic signed [15:0]        out_temperature_out,
  output logic [23:0]               out_status_word,
  output logic [31:0]               out_board_word
);

  localparam int unsigned ENTRY_W = $bits(ims_pkg::entry_t);

  logic              push, q_ready, q_valid, pop;
  ims_pkg::entry_t   push_entry, head;
  logic [ENTRY_W-1:0] head_bits;

  ims_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .msg_counter     (in_msg_counter),
    .status_byte     (in_status_byte),
    .raw_accel_x     (in_raw_accel_x),
    .raw_accel_y     (in_raw_accel_y),
    .raw_accel_z     (in_raw_accel_z),
    .raw_rate_x      (in_raw_rate_x),
    .raw_rate_y      (in_raw_rate_y),
    .raw_rate_z      (in_raw_rate_z),
    .raw_temperature (in_raw_temperature),
    .push            (push),
    .q_ready         (q_ready),
    .push_entry      (push_entry)
  );

  ims_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (q_ready),
    .push_data  (push_entry),
    .pop        (pop),
    .pop_valid  (q_valid),
    .pop_data   (head_bits)
  );

  assign head = ims_pkg::entry_t'(head_bits);

  ims_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .pop             (pop),
    .head            (head),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .scale_known     (out_scale_known),
    .accel_x_out     (out_accel_x_out),
    .accel_y_out     (out_accel_y_out),
    .accel_z_out     (out_accel_z_out),
    .rate_x_out      (out_rate_x_out),
    .rate_y_out      (out_rate_y_out),
    .rate_z_out      (out_rate_z_out),
    .temperature_out (out_temperature_out),
    .status_word     (out_status_word),
    .board_word      (out_board_word)
  );

endmodule

`default_nettype wire

[hw/rtl/ims_front.sv]
// Front end: accepts messages, routes the status byte into the stored state and
// pushes a classified entry into the queue. Depends on ims_pkg.
`default_nettype none

module ims_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           msg_counter,
  input  wire logic [7:0]           status_byte,
  input  wire logic signed [31:0]   raw_accel_x,
  input  wire logic signed [31:0]   raw_accel_y,
  input  wire logic signed [31:0]   raw_accel_z,
  input  wire logic signed [31:0]   raw_rate_x,
  input  wire logic signed [31:0]   raw_rate_y,
  input  wire logic signed [31:0]   raw_rate_z,
  input  wire logic signed [15:0]   raw_temperature,
  output logic                      push,
  input  wire logic                 q_ready,
  output ims_pkg::entry_t           push_entry
);

  ims_pkg::accel_mult_t accel_mult_r, accel_mult_nxt;
  ims_pkg::rate_mult_t  rate_mult_r, rate_mult_nxt;
  logic [7:0]           flags_r, flags_nxt;
  logic [7:0]           scale_r, scale_nxt;
  logic [7:0]           filter_r, filter_nxt;
  logic [3:0][7:0]      board_r, board_nxt;
  logic                 unread;

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

  assign unread = (msg_counter == ims_pkg::REV_COUNT) || (msg_counter == ims_pkg::PROD_COUNT) ||
                  (msg_counter >= ims_pkg::BOARD_END);

  // The status byte takes effect before the same message is scaled, so the
  // entry carries the updated state.
  always_comb begin
    accel_mult_nxt = accel_mult_r;
    rate_mult_nxt  = rate_mult_r;
    flags_nxt      = flags_r;
    scale_nxt      = scale_r;
    filter_nxt     = filter_r;
    board_nxt      = board_r;
    if (!unread) begin
      priority if (msg_counter == ims_pkg::FILTER_COUNT) begin
        filter_nxt = status_byte;
      end else if (msg_counter >= ims_pkg::BOARD_FIRST) begin
        board_nxt[msg_counter[1:0]] = status_byte;
      end else if (status_byte[ims_pkg::SCALE_SEL_BIT]) begin
        accel_mult_nxt = ims_pkg::accel_mult_of(status_byte[3:1]);
        rate_mult_nxt  = ims_pkg::rate_mult_of(status_byte & ims_pkg::RATE_CODE_MASK);
        scale_nxt      = status_byte;
      end else begin
        flags_nxt = status_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_mult_r <= '0;
      rate_mult_r  <= '0;
      flags_r      <= '0;
      scale_r      <= '0;
      filter_r     <= '0;
      board_r      <= '0;
    end else if (push) begin
      accel_mult_r <= accel_mult_nxt;
      rate_mult_r  <= rate_mult_nxt;
      flags_r      <= flags_nxt;
      scale_r      <= scale_nxt;
      filter_r     <= filter_nxt;
      board_r      <= board_nxt;
    end
  end

  always_comb begin
    push_entry.accel_mult  = accel_mult_nxt;
    push_entry.rate_mult   = rate_mult_nxt;
    push_entry.raw_accel_x = raw_accel_x;
    push_entry.raw_accel_y = raw_accel_y;
    push_entry.raw_accel_z = raw_accel_z;
    push_entry.raw_rate_x  = raw_rate_x;
    push_entry.raw_rate_y  = raw_rate_y;
    push_entry.raw_rate_z  = raw_rate_z;
    push_entry.temperature = raw_temperature;
    push_entry.status_word = {filter_nxt, scale_nxt, flags_nxt};
    push_entry.board_word  = board_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/ims_queue.sv]
// Short first-in first-out queue between the front end and the scaler.
// Generic in width and depth; depends on nothing.
`default_nettype none

module ims_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  pop_valid,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ims_back.sv]
// Back end: scales and saturates the axes of the queue head into the output register.
// Depends on ims_pkg.
`default_nettype none

module ims_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  output logic                      pop,
  input  wire ims_pkg::entry_t      head,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      scale_known,
  output logic signed [31:0]        accel_x_out,
  output logic signed [31:0]        accel_y_out,
  output logic signed [31:0]        accel_z_out,
  output logic signed [31:0]        rate_x_out,
  output logic signed [31:0]        rate_y_out,
  output logic signed [31:0]        rate_z_out,
  output logic signed [15:0]        temperature_out,
  output logic [23:0]               status_word,
  output logic [31:0]               board_word
);

  logic                 out_valid_r;
  logic                 scale_known_r;
  logic signed [31:0]   accel_x_r, accel_y_r, accel_z_r;
  logic signed [31:0]   rate_x_r, rate_y_r, rate_z_r;
  logic signed [15:0]   temp_r;
  logic [23:0]          status_r;
  logic [31:0]          board_r;
  ims_pkg::rate_mult_t  accel_mult_ext;

  // The output register takes a new transfer whenever it is empty or being drained.
  assign pop            = q_valid && (!out_valid_r || out_ready);
  assign accel_mult_ext = {1'b0, head.accel_mult};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      scale_known_r <= (head.accel_mult != '0);
      accel_x_r     <= ims_pkg::sat_mul(head.raw_accel_x, accel_mult_ext);
      accel_y_r     <= ims_pkg::sat_mul(head.raw_accel_y, accel_mult_ext);
      accel_z_r     <= ims_pkg::sat_mul(head.raw_accel_z, accel_mult_ext);
      rate_x_r      <= ims_pkg::sat_mul(head.raw_rate_x, head.rate_mult);
      rate_y_r      <= ims_pkg::sat_mul(head.raw_rate_y, head.rate_mult);
      rate_z_r      <= ims_pkg::sat_mul(head.raw_rate_z, head.rate_mult);
      temp_r        <= head.temperature;
      status_r      <= head.status_word;
      board_r       <= head.board_word;
    end
  end

  assign out_valid       = out_valid_r;
  assign scale_known     = scale_known_r;
  assign accel_x_out     = accel_x_r;
  assign accel_y_out     = accel_y_r;
  assign accel_z_out     = accel_z_r;
  assign rate_x_out      = rate_x_r;
  assign rate_y_out      = rate_y_r;
  assign rate_z_out      = rate_z_r;
  assign temperature_out = temp_r;
  assign status_word     = status_r;
  assign board_word      = board_r;

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for imu_status_demux_and_scaling: directed and random messages,
// with a result predictor kept in a small scoreboard class.
// Depends on ims_pkg and the top level of the block; reads no files.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned RANDOM_MESSAGES = 650;
  localparam int unsigned LIMIT_CYCLES    = 200000;
  localparam int unsigned LONG_HOLD       = 60;

  typedef struct packed {
    logic [7:0]         counter;
    logic [7:0]         status;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [15:0] temp;
  } imu_msg_t;

  typedef struct packed {
    logic               scale_known;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [15:0] temp;
    logic [23:0]        status_word;
    logic [31:0]        board_word;
  } imu_result_t;

  // Tracks the stored status bytes and multipliers and holds the results still to come.
  class imu_result_book;
    int unsigned accel_gain;
    int unsigned rate_gain;
    logic [7:0]  flags_byte;
    logic [7:0]  scale_byte;
    logic [7:0]  filter_byte;
    logic [7:0]  board_bytes [4];
    imu_result_t expected_results [$];
    int unsigned failures;

    function new();
      accel_gain  = 0;
      rate_gain   = 0;
      flags_byte  = '0;
      scale_byte  = '0;
      filter_byte = '0;
      foreach (board_bytes[i]) board_bytes[i] = '0;
      failures    = 0;
    endfunction

    function automatic logic signed [31:0] scaled(logic signed [31:0] raw, int unsigned gain);
      longint p;
      p = longint'(raw) * longint'(gain);
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p[31:0];
    endfunction

    function void note_message(imu_msg_t m);
      imu_result_t r;
      logic [7:0]  board_index;
      if (m.counter == ims_pkg::REV_COUNT || m.counter == ims_pkg::PROD_COUNT ||
          m.counter >= ims_pkg::BOARD_END) begin
        // Revision, product, release and serial bytes leave the state alone.
      end else if (m.counter == ims_pkg::FILTER_COUNT) begin
        filter_byte = m.status;
      end else if (m.counter >= ims_pkg::BOARD_FIRST) begin
        board_index = m.counter - ims_pkg::BOARD_FIRST;
        board_bytes[board_index[1:0]] = m.status;
      end else if (m.status[ims_pkg::SCALE_SEL_BIT]) begin
        case (m.status[3:1])
          3'd1, 3'd2:       accel_gain = 1;
          3'd3, 3'd4, 3'd5: accel_gain = 5;
          3'd7:             accel_gain = 20;
          default:          accel_gain = 10;
        endcase
        case (m.status & ims_pkg::RATE_CODE_MASK)
          ims_pkg::RATE_CODE_15: rate_gain = 15;
          ims_pkg::RATE_CODE_50: rate_gain = 50;
          ims_pkg::RATE_CODE_5:  rate_gain = 5;
          default:               rate_gain = 10;
        endcase
        scale_byte = m.status;
      end else begin
        flags_byte = m.status;
      end

      // The status byte of a message takes effect before that message is scaled.
      r.scale_known = (accel_gain != 0);
      r.ax          = scaled(m.ax, accel_gain);
      r.ay          = scaled(m.ay, accel_gain);
      r.az          = scaled(m.az, accel_gain);
      r.rx          = scaled(m.rx, rate_gain);
      r.ry          = scaled(m.ry, rate_gain);
      r.rz          = scaled(m.rz, rate_gain);
      r.temp        = m.temp;
      r.status_word = {filter_byte, scale_byte, flags_byte};
      r.board_word  = {board_bytes[3], board_bytes[2], board_bytes[1], board_bytes[0]};
      expected_results.push_back(r);
    endfunction

    task report(string what);
      failures++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task compare(string field, longint got, longint want);
      if (got != want) report($sformatf("%s got %0d, expected %0d", field, got, want));
    endtask

    task check_result(imu_result_t got);
      imu_result_t want;
      if (expected_results.size() == 0) begin
        report("result transfer with no message pending");
        return;
      end
      want = expected_results.pop_front();
      compare("scale_known", got.scale_known, want.scale_known);
      compare("accel_x", got.ax, want.ax);
      compare("accel_y", got.ay, want.ay);
      compare("accel_z", got.az, want.az);
      compare("rate_x", got.rx, want.rx);
      compare("rate_y", got.ry, want.ry);
      compare("rate_z", got.rz, want.rz);
      compare("temperature", got.temp, want.temp);
      compare("status_word", got.status_word, want.status_word);
      compare("board_word", got.board_word, want.board_word);
    endtask

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_msg_counter;
  logic [7:0]         in_status_byte;
  logic signed [31:0] in_raw_accel_x;
  logic signed [31:0] in_raw_accel_y;
  logic signed [31:0] in_raw_accel_z;
  logic signed [31:0] in_raw_rate_x;
  logic signed [31:0] in_raw_rate_y;
  logic signed [31:0] in_raw_rate_z;
  logic signed [15:0] in_raw_temperature;
  logic               out_valid;
  logic               out_ready;
  logic               out_scale_known;
  logic signed [31:0] out_accel_x_out;
  logic signed [31:0] out_accel_y_out;
  logic signed [31:0] out_accel_z_out;
  logic signed [31:0] out_rate_x_out;
  logic signed [31:0] out_rate_y_out;
  logic signed [31:0] out_rate_z_out;
  logic signed [15:0] out_temperature_out;
  logic [23:0]        out_status_word;
  logic [31:0]        out_board_word;

  imu_result_book book;
  logic           calm_in;
  logic           calm_out;
  logic           hold_request;
  int unsigned    cycles;

  imu_status_demux_and_scaling i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_msg_counter      (in_msg_counter),
    .in_status_byte      (in_status_byte),
    .in_raw_accel_x      (in_raw_accel_x),
    .in_raw_accel_y      (in_raw_accel_y),
    .in_raw_accel_z      (in_raw_accel_z),
    .in_raw_rate_x       (in_raw_rate_x),
    .in_raw_rate_y       (in_raw_rate_y),
    .in_raw_rate_z       (in_raw_rate_z),
    .in_raw_temperature  (in_raw_temperature),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_scale_known     (out_scale_known),
    .out_accel_x_out     (out_accel_x_out),
    .out_accel_y_out     (out_accel_y_out),
    .out_accel_z_out     (out_accel_z_out),
    .out_rate_x_out      (out_rate_x_out),
    .out_rate_y_out      (out_rate_y_out),
    .out_rate_z_out      (out_rate_z_out),
    .out_temperature_out (out_temperature_out),
    .out_status_word     (out_status_word),
    .out_board_word      (out_board_word)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stalls, a calm stretch, and one long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm_out || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  always @(posedge clk) begin
    imu_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.scale_known = out_scale_known;
      got.ax          = out_accel_x_out;
      got.ay          = out_accel_y_out;
      got.az          = out_accel_z_out;
      got.rx          = out_rate_x_out;
      got.ry          = out_rate_y_out;
      got.rz          = out_rate_z_out;
      got.temp        = out_temperature_out;
      got.status_word = out_status_word;
      got.board_word  = out_board_word;
      book.check_result(got);
    end
  end

  task automatic send_message(imu_msg_t m);
    int unsigned gaps;
    gaps = 0;
    if (!calm_in) begin
      while (gaps < 8 && $urandom_range(0, 99) < 33) gaps++;
    end
    @(negedge clk);
    while (gaps > 0) begin
      in_valid <= 1'b0;
      gaps--;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_msg_counter     <= m.counter;
    in_status_byte     <= m.status;
    in_raw_accel_x     <= m.ax;
    in_raw_accel_y     <= m.ay;
    in_raw_accel_z     <= m.az;
    in_raw_rate_x      <= m.rx;
    in_raw_rate_y      <= m.ry;
    in_raw_rate_z      <= m.rz;
    in_raw_temperature <= m.temp;
    do @(posedge clk); while (!in_ready);
    book.note_message(m);
  endtask

  function automatic imu_msg_t make_message(logic [7:0] counter, logic [7:0] status,
                                            logic signed [31:0] a, logic signed [31:0] r,
                                            logic signed [15:0] temp);
    imu_msg_t m;
    m.counter = counter;
    m.status  = status;
    m.ax      = a;
    m.ay      = ~a;
    m.az      = -32'sd1;
    m.rx      = r;
    m.ry      = ~r;
    m.rz      = 32'sd12345678;
    m.temp    = temp;
    return m;
  endfunction

  // Full-range, small and extreme values, some near the saturation points of each gain.
  function automatic logic signed [31:0] random_axis();
    logic signed [31:0] a;
    int unsigned        gain;
    longint             v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: a = 32'($urandom);
      4, 5:       a = int'($urandom_range(0, 2000)) - 1000;
      6:          a = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      7: begin
        case ($urandom_range(0, 5))
          0:       gain = 1;
          1:       gain = 5;
          2:       gain = 10;
          3:       gain = 15;
          4:       gain = 20;
          default: gain = 50;
        endcase
        v = longint'(2147483647 / gain) + longint'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) v = -v - longint'($urandom_range(0, 1));
        a = v[31:0];
      end
      8:          a = $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      default:    a = 32'sd1;
    endcase
    return a;
  endfunction

  function automatic imu_msg_t random_message();
    imu_msg_t    m;
    int unsigned kind;
    kind      = $urandom_range(0, 99);
    m.counter = 8'($urandom);
    m.status  = 8'($urandom);
    if (kind >= 40 && kind < 65) begin
      m.counter = 8'($urandom_range(2, 246));
      m.status[ims_pkg::SCALE_SEL_BIT] = 1'b1;
    end else if (kind >= 65 && kind < 78) begin
      m.counter = 8'($urandom_range(2, 246));
      m.status[ims_pkg::SCALE_SEL_BIT] = 1'b0;
    end else if (kind >= 78 && kind < 84) begin
      m.counter = ims_pkg::FILTER_COUNT;
    end else if (kind >= 84 && kind < 94) begin
      m.counter = ims_pkg::BOARD_FIRST + 8'($urandom_range(0, 3));
    end else if (kind >= 94) begin
      m.counter = $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) :
                                         8'($urandom_range(ims_pkg::BOARD_END, 255));
    end
    m.ax = random_axis();
    m.ay = random_axis();
    m.az = random_axis();
    m.rx = random_axis();
    m.ry = random_axis();
    m.rz = random_axis();
    case ($urandom_range(0, 9))
      0:       m.temp = 16'sh7fff;
      1:       m.temp = 16'sh8000;
      default: m.temp = 16'($urandom);
    endcase
    return m;
  endfunction

  initial begin
    logic [7:0] rate_bits [8];
    logic [7:0] code;
    book               = new();
    cycles             = 0;
    calm_in            = 1'b0;
    calm_out           = 1'b0;
    hold_request       = 1'b0;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_msg_counter     = '0;
    in_status_byte     = '0;
    in_raw_accel_x     = '0;
    in_raw_accel_y     = '0;
    in_raw_accel_z     = '0;
    in_raw_rate_x      = '0;
    in_raw_rate_y      = '0;
    in_raw_rate_z      = '0;
    in_raw_temperature = '0;
    rate_bits = '{8'h00, 8'h01, 8'h10, 8'h11, 8'h20, 8'h21, 8'h30, 8'h31};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // No scale seen yet: results come out with zero axes.
    send_message(make_message(8'd2, 8'h00, 32'sh7fffffff, 32'sh80000000, 16'sh7fff));
    send_message(make_message(8'd246, 8'hbf, 32'sh80000000, 32'sh7fffffff, 16'sh8000));
    // Unread counters carry scale-like bytes that must change nothing.
    send_message(make_message(ims_pkg::REV_COUNT, 8'h7f, 32'sd1000, 32'sd1000, 16'sd0));
    send_message(make_message(ims_pkg::PROD_COUNT, 8'h4e, 32'sd1000, 32'sd1000, 16'sd1));
    send_message(make_message(ims_pkg::BOARD_END, 8'h40, 32'sd1000, 32'sd1000, 16'sd2));
    send_message(make_message(8'd255, 8'hff, 32'sd1000, 32'sd1000, 16'sd3));
    send_message(make_message(ims_pkg::FILTER_COUNT, 8'ha5, 32'sd0, 32'sd0, -16'sd1));
    for (int i = 0; i < 4; i++) begin
      send_message(make_message(ims_pkg::BOARD_FIRST + 8'(i), 8'h5a ^ 8'(8'h81 << i),
                                32'sd7, -32'sd7, 16'(i)));
    end
    // Each acceleration code paired with one of the rate bit patterns, saturating inputs.
    for (int i = 0; i < 8; i++) begin
      code = 8'h40 | 8'(i << 1) | rate_bits[i] | ((i % 2) ? 8'h80 : 8'h00);
      send_message(make_message(8'(2 + 30 * i), code, 32'sh7fffffff, 32'sh80000000,
                                (i % 2) ? 16'sh7fff : 16'sh8000));
    end
    send_message(make_message(8'd100, 8'h3f, 32'sd214748364, -32'sd214748365, 16'sd25));
    send_message(make_message(8'd200, 8'hff, 32'sd107374183, -32'sd107374184, -16'sd25));

    for (int n = 0; n < RANDOM_MESSAGES; n++) begin
      calm_in  = (n >= 200 && n < 330) || (n >= 450 && n < 520);
      calm_out = (n >= 200 && n < 330);
      // The receiver holds off while the sender keeps offering, so the queue fills.
      if (n == 450) hold_request = 1'b1;
      send_message(random_message());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (book.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (book.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
